// ===== design/assert_macros.svh =====
// assertion macros shared by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sfs_pkg.sv =====
// types and constants of the sprite frame sequencer
`default_nettype none

package sfs_pkg;

	// field widths
	localparam int PATTERN_BITS = 10;
	localparam int OPCODE_W     = 2;
	localparam int TINDEX_W     = 6;
	localparam int TLEN_W       = 7;
	localparam int INTERVAL_W   = 16;
	localparam int TICK_W       = 17;
	localparam int CELL_W       = 16;
	localparam int MODE_W       = 3;
	localparam int ORIGIN_W     = 25;
	localparam int PROD_W       = PATTERN_BITS + CELL_W;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [ORIGIN_W-1:0] ORIGIN_MAX = '1;

	// item opcodes
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_TOP   = 2'd2,
		OP_WRITE = 2'd3
	} opcode_t;

	// animation modes
	typedef enum logic [MODE_W-1:0] {
		MODE_FWD_LOOP = 3'd0,
		MODE_REV_LOOP = 3'd1,
		MODE_FWD_ONCE = 3'd2,
		MODE_REV_ONCE = 3'd3,
		MODE_PINGPONG = 3'd4,
		MODE_TBL_LOOP = 3'd5,
		MODE_TBL_ONCE = 3'd6,
		MODE_STILL    = 3'd7
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_TOP      = 3'd0,
		REG_RANGE_BOTTOM   = 3'd1,
		REG_FRAME_INTERVAL = 3'd2,
		REG_FLIP_MODE      = 3'd3,
		REG_COLUMNS        = 3'd4,
		REG_CELL_WIDTH     = 3'd5,
		REG_CELL_HEIGHT    = 3'd6,
		REG_TABLE_LENGTH   = 3'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_STEP = 5'b00010,
		S_DIV  = 5'b00100,
		S_MUL  = 5'b01000,
		S_LOAD = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== design/sfs_if.sv =====
// item and result channel interfaces of the sprite frame sequencer
`default_nettype none

interface sfs_item_if;
	logic                              valid;
	logic                              ready;
	logic [sfs_pkg::OPCODE_W-1:0]      opcode;
	logic [sfs_pkg::PATTERN_BITS-1:0]  pattern_value;
	logic [sfs_pkg::TINDEX_W-1:0]      table_index;
	logic [sfs_pkg::PATTERN_BITS-1:0]  table_value;

	modport source (output valid, output opcode, output pattern_value, output table_index,
		output table_value, input ready);
	modport sink (input valid, input opcode, input pattern_value, input table_index,
		input table_value, output ready);
endinterface

interface sfs_result_if;
	logic                              valid;
	logic                              ready;
	logic [sfs_pkg::PATTERN_BITS-1:0]  pattern_now;
	logic [sfs_pkg::ORIGIN_W-1:0]      u_origin;
	logic [sfs_pkg::ORIGIN_W-1:0]      v_origin;
	logic                              finished_event;

	modport source (output valid, output pattern_now, output u_origin, output v_origin,
		output finished_event, input ready);
	modport sink (input valid, input pattern_now, input u_origin, input v_origin,
		input finished_event, output ready);
endinterface

`default_nettype wire

// ===== design/sprite_frame_sequencer.sv =====
// sprite frame sequencer top level: pattern stepping, order table and uv origin
//
//  channel  | dir | payload                                          | beat when
//  ---------+-----+--------------------------------------------------+------------------
//  item     | in  | opcode, pattern_value, table_index, table_value  | valid && ready
//  result   | out | pattern_now, u_origin, v_origin, finished_event  | valid && ready
//  cfg      | in  | cfg_index, cfg_data                              | cfg_we
//
// an item passes through an accept step with the order table read, an update step,
// the restoring divider for column and row at one quotient bit per cycle, a multiply
// step and an output load.
// one item is in flight at a time; the result register lets the next item be taken
// while a result waits, and a stalled result holds the load stage.
// arst_n clears the control state and resets the config to its defaults; the order table is not cleared.
`default_nettype none
`include "assert_macros.svh"

module sprite_frame_sequencer #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	sfs_item_if.sink                               item,
	sfs_result_if.source                           result,
	input  wire logic                              cfg_we,
	input  wire logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int PB = sfs_pkg::PATTERN_BITS;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = $clog2(PB);
	localparam int TW = sfs_pkg::TICK_W;
	localparam int RW = sfs_pkg::PROD_W;

	// configuration registers
	logic [PB-1:0]                      range_top_q;
	logic [PB-1:0]                      range_bottom_q;
	logic [sfs_pkg::INTERVAL_W-1:0]     frame_interval_q;
	sfs_pkg::mode_t                     flip_mode_q;
	logic [PB-1:0]                      columns_q;
	logic [sfs_pkg::CELL_W-1:0]         cell_width_q;
	logic [sfs_pkg::CELL_W-1:0]         cell_height_q;
	logic [sfs_pkg::TLEN_W-1:0]         table_length_q;

	// sequencer state
	sfs_pkg::state_t                    state_q;
	logic [PB-1:0]                      pattern_q;
	logic [TW-1:0]                      tick_q;
	logic                               back_q;
	logic [AW-1:0]                      cursor_q;
	logic                               stopped_q;
	sfs_pkg::opcode_t                   op_q;
	logic [PB-1:0]                      pv_q;
	logic                               step_q;
	logic                               fin_q;
	logic [PB-1:0]                      quo_q;
	logic [PB-1:0]                      rem_q;
	logic [CW-1:0]                      div_cnt_q;
	logic [RW-1:0]                      u_prod_q;
	logic [RW-1:0]                      v_prod_q;

	// result register
	logic                               out_valid_q;
	logic [PB-1:0]                      pattern_now_q;
	logic [sfs_pkg::ORIGIN_W-1:0]       u_origin_q;
	logic [sfs_pkg::ORIGIN_W-1:0]       v_origin_q;
	logic                               finished_q;

	// order table
	logic [PB-1:0]                      order_mem [TABLE_DEPTH];
	logic [PB-1:0]                      rd_data_q;

	logic                               accept;
	logic [TW-1:0]                      tick_inc;
	logic                               tbl_we;
	logic [LW-1:0]                      len;
	logic [AW-1:0]                      cur_rd;
	logic [LW-1:0]                      cur_inc;
	logic                               cur_wrap;
	logic [AW-1:0]                      cur_next;
	logic [PB-1:0]                      pat_nx;
	logic                               back_nx;
	logic [AW-1:0]                      cursor_nx;
	logic                               fin_nx;
	logic [PB-1:0]                      divisor;
	logic [PB:0]                        trial;
	logic                               q_bit;
	logic [PB-1:0]                      rem_nx;
	logic                               load;

	// handshake
	assign item.ready = (state_q == sfs_pkg::S_IDLE);
	assign accept     = item.valid && item.ready;
	assign load       = (state_q == sfs_pkg::S_LOAD) && (!out_valid_q || result.ready);

	assign result.valid          = out_valid_q;
	assign result.pattern_now    = pattern_now_q;
	assign result.u_origin       = u_origin_q;
	assign result.v_origin       = v_origin_q;
	assign result.finished_event = finished_q;

	assign tick_inc = tick_q + TW'(1);

	// table cursor arithmetic, length limited to the table depth
	always_comb begin
		if (32'(table_length_q) > 32'(TABLE_DEPTH)) begin
			len = LW'(TABLE_DEPTH);
		end else begin
			len = LW'(table_length_q);
		end
		cur_rd   = (LW'(cursor_q) >= len) ? '0 : cursor_q;
		cur_inc  = LW'(cur_rd) + LW'(1);
		cur_wrap = (cur_inc >= len);
		cur_next = cur_wrap ? '0 : AW'(cur_inc);
	end

	// table write on a write beat inside the table
	assign tbl_we = accept && (item.opcode == sfs_pkg::OP_WRITE)
		&& (32'(item.table_index) < 32'(TABLE_DEPTH));

	// order table memory, read data registered
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			order_mem[AW'(item.table_index)] <= item.table_value;
		end
		rd_data_q <= order_mem[cur_rd];
	end

	// next pattern for the update cycle
	always_comb begin
		pat_nx    = pattern_q;
		back_nx   = back_q;
		cursor_nx = cursor_q;
		fin_nx    = 1'b0;
		unique case (op_q)
			sfs_pkg::OP_TICK: begin
				if (step_q) begin
					unique case (flip_mode_q)
						sfs_pkg::MODE_FWD_LOOP: begin
							pat_nx = (range_bottom_q > pattern_q) ? pattern_q + PB'(1) : range_top_q;
						end
						sfs_pkg::MODE_REV_LOOP: begin
							pat_nx = (range_top_q < pattern_q) ? pattern_q - PB'(1) : range_bottom_q;
						end
						sfs_pkg::MODE_FWD_ONCE: begin
							if (range_bottom_q > pattern_q) begin
								pat_nx = pattern_q + PB'(1);
							end else begin
								pat_nx = range_bottom_q;
								fin_nx = 1'b1;
							end
						end
						sfs_pkg::MODE_REV_ONCE: begin
							if (range_top_q < pattern_q) begin
								pat_nx = pattern_q - PB'(1);
							end else begin
								pat_nx = range_top_q;
								fin_nx = 1'b1;
							end
						end
						sfs_pkg::MODE_PINGPONG: begin
							if (back_q) begin
								if (range_top_q < pattern_q) begin
									pat_nx = pattern_q - PB'(1);
								end else begin
									back_nx = 1'b0;
									if (range_bottom_q > pattern_q) begin
										pat_nx = pattern_q + PB'(1);
									end
								end
							end else begin
								if (range_bottom_q > pattern_q) begin
									pat_nx = pattern_q + PB'(1);
								end else begin
									back_nx = 1'b1;
									if (range_top_q < pattern_q) begin
										pat_nx = pattern_q - PB'(1);
									end
								end
							end
						end
						sfs_pkg::MODE_TBL_LOOP, sfs_pkg::MODE_TBL_ONCE: begin
							if (len != '0) begin
								pat_nx    = rd_data_q;
								cursor_nx = cur_next;
								fin_nx    = (flip_mode_q == sfs_pkg::MODE_TBL_ONCE) && cur_wrap;
							end
						end
						sfs_pkg::MODE_STILL: begin
						end
						default: begin
						end
					endcase
				end
			end
			sfs_pkg::OP_SET: begin
				if (pv_q < range_top_q) begin
					pat_nx = range_top_q;
				end else if (pv_q > range_bottom_q) begin
					pat_nx = range_bottom_q;
				end else begin
					pat_nx = pv_q;
				end
			end
			sfs_pkg::OP_TOP: begin
				pat_nx = range_top_q;
			end
			sfs_pkg::OP_WRITE: begin
			end
			default: begin
			end
		endcase
	end

	// restoring divider step, one quotient bit per cycle
	always_comb begin
		divisor = (columns_q == '0) ? PB'(1) : columns_q;
		trial   = {rem_q, quo_q[PB-1]};
		q_bit   = (trial >= {1'b0, divisor});
		rem_nx  = q_bit ? PB'(trial - {1'b0, divisor}) : PB'(trial);
	end

	// control, datapath and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= sfs_pkg::S_IDLE;
			pattern_q        <= '0;
			tick_q           <= '0;
			back_q           <= 1'b0;
			cursor_q         <= '0;
			stopped_q        <= 1'b0;
			op_q             <= sfs_pkg::OP_TICK;
			pv_q             <= '0;
			step_q           <= 1'b0;
			fin_q            <= 1'b0;
			quo_q            <= '0;
			rem_q            <= '0;
			div_cnt_q        <= '0;
			u_prod_q         <= '0;
			v_prod_q         <= '0;
			out_valid_q      <= 1'b0;
			pattern_now_q    <= '0;
			u_origin_q       <= '0;
			v_origin_q       <= '0;
			finished_q       <= 1'b0;
			range_top_q      <= '0;
			range_bottom_q   <= '0;
			frame_interval_q <= sfs_pkg::INTERVAL_W'(1);
			flip_mode_q      <= sfs_pkg::MODE_FWD_LOOP;
			columns_q        <= PB'(1);
			cell_width_q     <= sfs_pkg::CELL_W'(32768);
			cell_height_q    <= sfs_pkg::CELL_W'(32768);
			table_length_q   <= '0;
		end else begin
			// result valid: set on a load, cleared when the beat is taken
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				sfs_pkg::S_IDLE: begin
					if (accept) begin
						op_q   <= sfs_pkg::opcode_t'(item.opcode);
						pv_q   <= item.pattern_value;
						step_q <= 1'b0;
						if (item.opcode == sfs_pkg::OP_TICK) begin
							if (tick_inc > TW'(frame_interval_q)) begin
								tick_q <= '0;
								step_q <= !stopped_q;
							end else begin
								tick_q <= tick_inc;
							end
						end
						state_q <= sfs_pkg::S_STEP;
					end
				end
				sfs_pkg::S_STEP: begin
					pattern_q <= pat_nx;
					back_q    <= back_nx;
					cursor_q  <= cursor_nx;
					fin_q     <= fin_nx;
					if (fin_nx) begin
						stopped_q <= 1'b1;
					end
					quo_q     <= pat_nx;
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= sfs_pkg::S_DIV;
				end
				sfs_pkg::S_DIV: begin
					rem_q     <= rem_nx;
					quo_q     <= {quo_q[PB-2:0], q_bit};
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(PB - 1)) begin
						state_q <= sfs_pkg::S_MUL;
					end
				end
				sfs_pkg::S_MUL: begin
					u_prod_q <= RW'(rem_q) * RW'(cell_width_q);
					v_prod_q <= RW'(quo_q) * RW'(cell_height_q);
					state_q  <= sfs_pkg::S_LOAD;
				end
				sfs_pkg::S_LOAD: begin
					if (load) begin
						pattern_now_q <= pattern_q;
						u_origin_q    <= (u_prod_q > RW'(sfs_pkg::ORIGIN_MAX))
							? sfs_pkg::ORIGIN_MAX : sfs_pkg::ORIGIN_W'(u_prod_q);
						v_origin_q    <= (v_prod_q > RW'(sfs_pkg::ORIGIN_MAX))
							? sfs_pkg::ORIGIN_MAX : sfs_pkg::ORIGIN_W'(v_prod_q);
						finished_q    <= fin_q;
						state_q       <= sfs_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= sfs_pkg::S_IDLE;
				end
			endcase

			// register writes
			if (cfg_we) begin
				unique case (sfs_pkg::reg_idx_t'(cfg_index))
					sfs_pkg::REG_RANGE_TOP:      range_top_q      <= cfg_data[PB-1:0];
					sfs_pkg::REG_RANGE_BOTTOM:   range_bottom_q   <= cfg_data[PB-1:0];
					sfs_pkg::REG_FRAME_INTERVAL: frame_interval_q <= cfg_data[sfs_pkg::INTERVAL_W-1:0];
					sfs_pkg::REG_FLIP_MODE: begin
						flip_mode_q <= sfs_pkg::mode_t'(cfg_data[sfs_pkg::MODE_W-1:0]);
						stopped_q   <= 1'b0;
					end
					sfs_pkg::REG_COLUMNS:        columns_q        <= cfg_data[PB-1:0];
					sfs_pkg::REG_CELL_WIDTH:     cell_width_q     <= cfg_data[sfs_pkg::CELL_W-1:0];
					sfs_pkg::REG_CELL_HEIGHT:    cell_height_q    <= cfg_data[sfs_pkg::CELL_W-1:0];
					sfs_pkg::REG_TABLE_LENGTH:   table_length_q   <= cfg_data[sfs_pkg::TLEN_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// checks on the sequencing
	`SFS_ASSERT_NXT(a_accept_to_step, clk, arst_n, accept, state_q == sfs_pkg::S_STEP, "accepted item did not enter update")
	`SFS_ASSERT_NXT(a_div_to_mul, clk, arst_n, (state_q == sfs_pkg::S_DIV) && (div_cnt_q == CW'(PB - 1)), state_q == sfs_pkg::S_MUL, "divider did not end after all quotient bits")
	`SFS_ASSERT_NXT(a_fin_only_tick, clk, arst_n, (state_q == sfs_pkg::S_STEP) && (op_q != sfs_pkg::OP_TICK), !fin_q, "finish flagged on a non-tick item")
	`SFS_ASSERT_NXT(a_stop_holds, clk, arst_n, stopped_q && !(cfg_we && (cfg_index == sfs_pkg::REG_FLIP_MODE)), stopped_q, "stop cleared without a mode write")

endmodule

`default_nettype wire
